[rtl/ffsa_pkg.sv]
// Shared types and constants of the first-fit slot allocator.
// Used by ffsa_slot_ram, ffsa_size_div and first_fit_slot_allocator.
package ffsa_pkg;

  // Widths of the item fields.
  localparam int SIZE_W   = 20;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_TAKEN = 2'd2;

  // Per-slot mark: taken, and continuation into the next slot.
  typedef struct packed {
    logic cont;
    logic taken;
  } mark_t;

endpackage

[rtl/ffsa_slot_ram.sv]
// Slot map storage: one write port and one read port with registered data.
// Depends on ffsa_pkg for the mark type.
module ffsa_slot_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  ffsa_pkg::mark_t      wr_data,
  input  logic [AW-1:0]        rd_addr,
  output ffsa_pkg::mark_t      rd_data
);
  import ffsa_pkg::*;

  mark_t mem [DEPTH];
  mark_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with the data registered.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/ffsa_size_div.sv]
// Divider by a constant: one multiply by a fixed-point reciprocal, result registered.
// Turns a byte size into a block count; depends on ffsa_pkg for widths.
module ffsa_size_div #(
  parameter int DIVISOR = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ffsa_pkg::SIZE_W-1:0] dividend,
  output logic                        done,
  output logic [ffsa_pkg::SIZE_W-1:0] quotient
);
  import ffsa_pkg::*;

  // With SH = SIZE_W + ceil(log2(DIVISOR)) and MULT = ceil(2^SH / DIVISOR),
  // (x * MULT) >> SH equals x / DIVISOR for every SIZE_W-bit x.
  localparam int            SH     = SIZE_W + $clog2(DIVISOR);
  localparam int            PW     = SH + SIZE_W;
  localparam int            MW     = SIZE_W + 1;
  localparam logic [63:0]   MULT64 = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] MULT   = MULT64[MW-1:0];

  logic              done_r, done_nxt;
  logic [SIZE_W-1:0] quot_r, quot_nxt;
  logic [PW-1:0]     prod;

  // One multiply; the quotient is the top SIZE_W bits of the product.
  always_comb begin
    prod     = PW'(dividend) * PW'(MULT);
    done_nxt = start;
    quot_nxt = start ? prod[PW-1:SH] : quot_r;
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

[rtl/first_fit_slot_allocator.sv]
// First-fit slot allocator: top level with the request sequencer.
// Depends on ffsa_pkg, ffsa_slot_ram and ffsa_size_div.
//
// Usage:
//   An item (allocate or free request) is taken at a rising edge where start
//   is high and busy is low. busy stays high while the item is worked on.
//   Each item gives one result on out_status, out_first_slot and
//   out_slots_changed, marked by out_valid for exactly one cycle; the
//   receiver cannot stall, so nothing waits on it.
//   Allocate: the byte size is turned into a slot count with a reciprocal
//   multiply, then the slot map is scanned at one slot per cycle through the
//   single map read port, then each slot of the found run is marked in turn.
//   Free: the walk clears each taken slot from the given slot on, and stops
//   after a slot with no continuation or the last slot, or at a free slot.
//   A free of a slot beyond the pool answers in the next cycle.
//   The result is shown in the first cycle with busy low; start may be high
//   in that same cycle.
//   Reset: a clearing pass writes every map entry free, one per cycle;
//   busy is high during it.
module first_fit_slot_allocator #(
  parameter int NUM_SLOTS   = 64,
  parameter int BLOCK_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [ffsa_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [ffsa_pkg::SLOT_W-1:0]   in_slot_index,
  output logic                          out_valid,
  output logic [ffsa_pkg::STATUS_W-1:0] out_status,
  output logic [ffsa_pkg::SLOT_W-1:0]   out_first_slot,
  output logic [ffsa_pkg::COUNT_W-1:0]  out_slots_changed
);
  import ffsa_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MARK,
    ST_FREE
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  more_r, more_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [AW-1:0]         chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]         run_start_r, run_start_nxt;
  logic [CW-1:0]         run_len_r, run_len_nxt;
  logic [CW-1:0]         need_r, need_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  first_r, first_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_first_r, out_first_nxt;
  logic [COUNT_W-1:0]    out_changed_r, out_changed_nxt;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  mark_t                 ram_wr_data;
  mark_t                 rd_mark;

  logic                  div_start;
  logic                  div_done;
  logic [SIZE_W-1:0]     div_q;

  logic [SIZE_W:0]       need_full;
  logic                  need_big;
  logic                  slot_oob;
  logic [CW-1:0]         run_len_inc;
  logic [CW-1:0]         cnt_inc;
  logic [15:0]           start_wide;
  logic [15:0]           need_wide;
  logic [15:0]           cnt_wide;
  logic [15:0]           cnt_inc_wide;

  // Slot map storage.
  ffsa_slot_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ptr_r),
    .rd_data (rd_mark)
  );

  // Byte size to block count.
  ffsa_size_div #(
    .DIVISOR (BLOCK_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_size_bytes),
    .done     (div_done),
    .quotient (div_q)
  );

  // Derived values for the sequencer.
  assign need_full    = {1'b0, div_q} + (SIZE_W + 1)'(1);
  assign need_big     = (need_full > (SIZE_W + 1)'(NUM_SLOTS));
  assign slot_oob     = (13'(in_slot_index) >= 13'(NUM_SLOTS));
  assign run_len_inc  = run_len_r + CW'(1);
  assign cnt_inc      = cnt_r + CW'(1);
  assign start_wide   = 16'(run_start_r);
  assign need_wide    = 16'(need_r);
  assign cnt_wide     = 16'(cnt_r);
  assign cnt_inc_wide = 16'(cnt_inc);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    more_nxt        = more_r;
    chk_v_nxt       = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    run_start_nxt   = run_start_r;
    run_len_nxt     = run_len_r;
    need_nxt        = need_r;
    cnt_nxt         = cnt_r;
    first_nxt       = first_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_first_nxt   = out_first_r;
    out_changed_nxt = out_changed_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = ptr_r;
    ram_wr_data     = '0;
    div_start       = 1'b0;

    case (state_r)
      // Write every slot free after reset.
      ST_CLEAR: begin
        ram_wr_en = 1'b1;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      // Take an item and start the matching walk.
      ST_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_FREE) begin
            if (slot_oob) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STATUS_NOT_TAKEN;
              out_first_nxt   = '0;
              out_changed_nxt = '0;
            end else begin
              state_nxt = ST_FREE;
              ptr_nxt   = AW'(in_slot_index);
              more_nxt  = 1'b1;
              first_nxt = 1'b1;
              cnt_nxt   = '0;
            end
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end

      // Wait for the block count, reject runs longer than the pool.
      ST_DIV: begin
        if (div_done) begin
          if (need_big) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STATUS_NO_SPACE;
            out_first_nxt   = '0;
            out_changed_nxt = '0;
            state_nxt       = ST_IDLE;
          end else begin
            need_nxt      = CW'(need_full);
            ptr_nxt       = '0;
            more_nxt      = 1'b1;
            run_start_nxt = '0;
            run_len_nxt   = '0;
            state_nxt     = ST_SCAN;
          end
        end
      end

      // Stream the map and track the current run of free slots.
      ST_SCAN: begin
        if (more_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = ptr_r;
          ptr_nxt     = ptr_r + 1'b1;
          more_nxt    = (ptr_r != LAST);
        end
        if (chk_v_r) begin
          if (rd_mark.taken) begin
            run_len_nxt   = '0;
            run_start_nxt = chk_idx_r + 1'b1;
          end else if (run_len_inc == need_r) begin
            ptr_nxt   = run_start_r;
            cnt_nxt   = '0;
            state_nxt = ST_MARK;
          end else begin
            run_len_nxt = run_len_inc;
          end
          if (chk_idx_r == LAST && !(!rd_mark.taken && run_len_inc == need_r)) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STATUS_NO_SPACE;
            out_first_nxt   = '0;
            out_changed_nxt = '0;
            state_nxt       = ST_IDLE;
          end
        end
      end

      // Mark the granted run, continuation on all but the last slot.
      ST_MARK: begin
        ram_wr_en         = 1'b1;
        ram_wr_data.taken = 1'b1;
        ram_wr_data.cont  = (cnt_inc != need_r);
        ptr_nxt           = ptr_r + 1'b1;
        cnt_nxt           = cnt_inc;
        if (cnt_inc == need_r) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STATUS_OK;
          out_first_nxt   = start_wide[SLOT_W-1:0];
          out_changed_nxt = need_wide[COUNT_W-1:0];
          state_nxt       = ST_IDLE;
        end
      end

      // Walk the run and clear it slot by slot.
      ST_FREE: begin
        if (more_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = ptr_r;
          ptr_nxt     = ptr_r + 1'b1;
          more_nxt    = (ptr_r != LAST);
        end
        if (chk_v_r) begin
          if (!rd_mark.taken) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = first_r ? STATUS_NOT_TAKEN : STATUS_OK;
            out_first_nxt   = '0;
            out_changed_nxt = first_r ? '0 : cnt_wide[COUNT_W-1:0];
            state_nxt       = ST_IDLE;
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = chk_idx_r;
            cnt_nxt     = cnt_inc;
            first_nxt   = 1'b0;
            if (!rd_mark.cont || chk_idx_r == LAST) begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STATUS_OK;
              out_first_nxt   = '0;
              out_changed_nxt = cnt_inc_wide[COUNT_W-1:0];
              state_nxt       = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      more_r      <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      more_r      <= more_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_idx_r     <= chk_idx_nxt;
    run_start_r   <= run_start_nxt;
    run_len_r     <= run_len_nxt;
    need_r        <= need_nxt;
    cnt_r         <= cnt_nxt;
    first_r       <= first_nxt;
    out_status_r  <= out_status_nxt;
    out_first_r   <= out_first_nxt;
    out_changed_r <= out_changed_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_first_slot    = out_first_r;
  assign out_slots_changed = out_changed_r;

`ifndef SYNTHESIS
  // A failed request changes nothing and names no slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> (out_slots_changed == '0 && out_first_slot == '0))
    else $error("failed request reports slots");

  // An accepted item either occupies the block or answers at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item was dropped");

  // The free run being tracked never reaches the needed length inside the scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (run_len_r < need_r))
    else $error("scan overran the needed run length");

  // Marking never writes more slots than were asked for.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (cnt_r < need_r))
    else $error("mark phase overran the run");

  // No result comes out of the clearing pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !out_valid)
    else $error("result during clearing pass");
`endif

endmodule
